/* rtl/bf3zp_pkg.sv */
// Shared types and constants of the 3x3 zero-padded box filter.
`default_nettype none

package bf3zp_pkg;

   // Line store geometry.
   localparam int MAX_WIDTH     = 64;
   localparam int ADDR_WIDTH    = $clog2(MAX_WIDTH);
   localparam int PIXEL_WIDTH   = 8;
   localparam int LINE_WORD     = 2 * PIXEL_WIDTH;

   // Register field widths and limits.
   localparam int FRAME_WIDTH_BITS  = 7;
   localparam int FRAME_HEIGHT_BITS = 11;
   localparam int OUT_ROW_BITS      = 10;
   localparam int HEIGHT_LIMIT      = 1024;

   localparam logic [FRAME_WIDTH_BITS-1:0]  WIDTH_RESET  = 7'd25;
   localparam logic [FRAME_HEIGHT_BITS-1:0] HEIGHT_RESET = 11'd25;

   // Configuration channel.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 11;

   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

   // Item operation codes.
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // Neighbourhood sum and division by nine through a reciprocal.
   localparam int SUM_BITS    = 12;
   localparam int RECIP_BITS  = 12;
   localparam int RECIP_SHIFT = 15;
   localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP_NINE = 12'd3641;

   typedef logic [PIXEL_WIDTH-1:0] pixel_type;

   // Which parts of the 3x3 window lie inside the frame for one result.
   typedef struct packed {
      logic top_ok;
      logic bottom_ok;
      logic left_ok;
      logic right_ok;
      logic last;
   } border_type;

endpackage

`default_nettype wire

/* rtl/bf3zp_if.sv */
// Channel interfaces of the box filter: pixel requests, results and register writes.
`default_nettype none

interface bf3zp_req_if;
   import bf3zp_pkg::*;

   logic      valid;
   logic      ready;
   logic      op;
   pixel_type pixel;

   modport source (output valid, output op, output pixel, input ready);
   modport sink   (input valid, input op, input pixel, output ready);
endinterface

interface bf3zp_rsp_if;
   import bf3zp_pkg::*;

   logic      valid;
   logic      ready;
   pixel_type mean;
   logic      last;

   modport source (output valid, output mean, output last, input ready);
   modport sink   (input valid, input mean, input last, output ready);
endinterface

interface bf3zp_csr_if;
   import bf3zp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/box_filter_3x3_zero_pad_top.sv */
// Top level of the streaming 3x3 box filter with zero padding.
// Latency: the result for pixel k reaches the output register through the line store
// stage and the sum stage after the transaction that carries input k+width+1 (line store read, window sum, divide).
// Throughput: one transaction per cycle while the output accepts results; the line store read-modify-write at one
// entry per pixel sets that figure, with forwarding when consecutive pixels share an entry.
// Reset (synchronous, active high) empties the pipeline, zeroes the window and the
// frame counters and loads width 25 and height 25; line store contents are kept.
`default_nettype none

module box_filter_3x3_zero_pad_top (
   input wire logic   clock,
   input wire logic   reset,
   bf3zp_req_if.sink  req_port,
   bf3zp_rsp_if.source rsp_port,
   bf3zp_csr_if.sink  csr_port
);
   import bf3zp_pkg::*;

   // Configuration registers.
   logic [FRAME_WIDTH_BITS-1:0]  frame_width_ff, frame_width_in;
   logic [FRAME_HEIGHT_BITS-1:0] frame_height_ff, frame_height_in;
   logic [FRAME_WIDTH_BITS-1:0]  w_eff;
   logic [FRAME_HEIGHT_BITS-1:0] h_eff;
   logic                         csr_fire;
   logic                         csr_restart;

   // Frame counters.
   logic [FRAME_HEIGHT_BITS-1:0] in_row_ff, in_row_in;
   logic [FRAME_WIDTH_BITS-1:0]  in_col_ff, in_col_in;
   logic [OUT_ROW_BITS-1:0]      out_row_ff, out_row_in;
   logic [FRAME_WIDTH_BITS-1:0]  out_col_ff, out_col_in;

   // Accept stage.
   logic       req_fire;
   logic       in_frame;
   logic       take;
   logic       emit;
   pixel_type  pixel_eff;
   border_type border;

   // Line store stage.
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_emit_ff;
   pixel_type             s1_pixel_ff;
   logic [ADDR_WIDTH-1:0] s1_addr_ff;
   border_type            s1_border_ff;
   logic                  fwd_ff, fwd_in;
   logic [LINE_WORD-1:0]  fwd_data_ff;
   logic                  s1_go;
   logic                  s1_move;
   logic                  s1_free;
   logic [LINE_WORD-1:0]  rd_data;
   logic [LINE_WORD-1:0]  line_word;
   logic [LINE_WORD-1:0]  wr_data;
   pixel_type             window_ff [9];
   pixel_type             window_in [9];
   pixel_type             win_shift [9];
   logic [2:0]            row_ok;
   logic [2:0]            col_ok;
   logic [8:0]            term_ok;
   logic [SUM_BITS-1:0]   sum_in;

   // Sum stage and output register.
   logic                 s2_valid_ff, s2_valid_in;
   logic [SUM_BITS-1:0]  s2_sum_ff;
   logic                 s2_last_ff;
   logic                 s2_free;
   logic                 s3_free;
   logic [PROD_BITS-1:0] product;
   logic                 rsp_valid_ff, rsp_valid_in;
   pixel_type            rsp_mean_ff;
   logic                 rsp_last_ff;

   // Register writes; an unknown index is taken and ignored.
   assign csr_port.ready = 1'b1;
   assign csr_fire = csr_port.valid && csr_port.ready;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      csr_restart     = 1'b0;
      if (csr_fire) begin
         unique case (csr_port.index)
            REG_FRAME_WIDTH: begin
               frame_width_in = csr_port.data[FRAME_WIDTH_BITS-1:0];
               csr_restart    = 1'b1;
            end
            REG_FRAME_HEIGHT: begin
               frame_height_in = csr_port.data;
               csr_restart     = 1'b1;
            end
            default: begin
               csr_restart = 1'b0;
            end
         endcase
      end
   end

   // Effective frame size: zero reads as one, oversize saturates.
   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = FRAME_WIDTH_BITS'(1);
      end else if (frame_width_ff > FRAME_WIDTH_BITS'(MAX_WIDTH)) begin
         w_eff = FRAME_WIDTH_BITS'(MAX_WIDTH);
      end else begin
         w_eff = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         h_eff = FRAME_HEIGHT_BITS'(1);
      end else if (frame_height_ff > FRAME_HEIGHT_BITS'(HEIGHT_LIMIT)) begin
         h_eff = FRAME_HEIGHT_BITS'(HEIGHT_LIMIT);
      end else begin
         h_eff = frame_height_ff;
      end
   end

   // Accept decisions. A flush inside the frame is dropped; past the frame every
   // item is a zero pixel.
   assign req_port.ready = s1_free;
   assign req_fire  = req_port.valid && req_port.ready;
   assign in_frame  = in_row_ff < h_eff;
   assign take      = req_fire && !(in_frame && (req_port.op == OP_FLUSH));
   assign pixel_eff = in_frame ? req_port.pixel : '0;
   assign emit      = (in_row_ff >= FRAME_HEIGHT_BITS'(2))
                   || ((in_row_ff == FRAME_HEIGHT_BITS'(1)) && (in_col_ff != '0));

   // Which neighbours of the next result fall inside the frame.
   always_comb begin
      border.top_ok    = out_row_ff != '0;
      border.bottom_ok = ({1'b0, out_row_ff} + FRAME_HEIGHT_BITS'(1)) < h_eff;
      border.left_ok   = out_col_ff != '0;
      border.right_ok  = (out_col_ff + FRAME_WIDTH_BITS'(1)) < w_eff;
      border.last      = !border.bottom_ok && !border.right_ok;
   end

   // Frame counter update; the last result returns them to the frame start.
   always_comb begin
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (csr_restart) begin
         in_row_in  = '0;
         in_col_in  = '0;
         out_row_in = '0;
         out_col_in = '0;
      end else if (take) begin
         if ((in_col_ff + FRAME_WIDTH_BITS'(1)) >= w_eff) begin
            in_col_in = '0;
            in_row_in = in_row_ff + FRAME_HEIGHT_BITS'(1);
         end else begin
            in_col_in = in_col_ff + FRAME_WIDTH_BITS'(1);
         end
         if (emit) begin
            if (border.last) begin
               in_row_in  = '0;
               in_col_in  = '0;
               out_row_in = '0;
               out_col_in = '0;
            end else if (!border.right_ok) begin
               out_col_in = '0;
               out_row_in = out_row_ff + OUT_ROW_BITS'(1);
            end else begin
               out_col_in = out_col_ff + FRAME_WIDTH_BITS'(1);
            end
         end
      end
   end

   // Line stores: upper in the high byte, middle in the low byte of one word.
   bf3zp_ram #(
      .WIDTH (LINE_WORD),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data),
      .rd_en   (take),
      .rd_addr (in_col_ff[ADDR_WIDTH-1:0]),
      .rd_data (rd_data)
   );

   // Stage handshake: items that give no result never wait for the sum stage.
   assign s1_go   = !s1_emit_ff || s2_free;
   assign s1_move = s1_valid_ff && s1_go;
   assign s1_free = !s1_valid_ff || s1_go;

   // Forward the word being written when the next read hits the same entry.
   assign fwd_in = take && s1_move && (s1_addr_ff == in_col_ff[ADDR_WIDTH-1:0]);

   assign line_word = fwd_ff ? fwd_data_ff : rd_data;
   assign wr_data   = {line_word[PIXEL_WIDTH-1:0], s1_pixel_ff};

   always_comb begin
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // Window shift: columns move left, the new column comes from the stores and input.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_shift[r*3]   = window_ff[r*3+1];
         win_shift[r*3+1] = window_ff[r*3+2];
      end
      win_shift[2] = line_word[LINE_WORD-1:PIXEL_WIDTH];
      win_shift[5] = line_word[PIXEL_WIDTH-1:0];
      win_shift[8] = s1_pixel_ff;
   end

   // Masked neighbourhood sum; padding positions count as zero.
   always_comb begin
      row_ok = {s1_border_ff.bottom_ok, 1'b1, s1_border_ff.top_ok};
      col_ok = {s1_border_ff.right_ok, 1'b1, s1_border_ff.left_ok};
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            term_ok[r*3+c] = row_ok[r] & col_ok[c];
         end
      end
      sum_in = '0;
      for (int i = 0; i < 9; i++) begin
         if (term_ok[i]) begin
            sum_in = sum_in + SUM_BITS'(win_shift[i]);
         end
      end
   end

   // Next window: cleared at a frame restart and after the last result, shifted when an item moves on.
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         window_in[i] = window_ff[i];
      end
      if (csr_restart || (s1_move && s1_emit_ff && s1_border_ff.last)) begin
         for (int i = 0; i < 9; i++) begin
            window_in[i] = '0;
         end
      end else if (s1_move) begin
         for (int i = 0; i < 9; i++) begin
            window_in[i] = win_shift[i];
         end
      end
   end

   // Sum stage and output register hand-off.
   assign s3_free = !rsp_valid_ff || rsp_port.ready;
   assign s2_free = !s2_valid_ff || s3_free;

   always_comb begin
      if (s1_move && s1_emit_ff) begin
         s2_valid_in = 1'b1;
      end else if (s3_free) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
      if (s2_valid_ff && s3_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Division by nine: multiply by the reciprocal and drop the fraction bits.
   assign product = PROD_BITS'(s2_sum_ff) * PROD_BITS'(RECIP_NINE);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
         in_row_ff       <= '0;
         in_col_ff       <= '0;
         out_row_ff      <= '0;
         out_col_ff      <= '0;
         s1_valid_ff     <= 1'b0;
         fwd_ff          <= 1'b0;
         s2_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         in_row_ff       <= in_row_in;
         in_col_ff       <= in_col_in;
         out_row_ff      <= out_row_in;
         out_col_ff      <= out_col_in;
         s1_valid_ff     <= s1_valid_in;
         if (take) begin
            fwd_ff <= fwd_in;
         end
         s2_valid_ff     <= s2_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         for (int i = 0; i < 9; i++) begin
            window_ff[i] <= window_in[i];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (take) begin
         s1_emit_ff   <= emit;
         s1_pixel_ff  <= pixel_eff;
         s1_addr_ff   <= in_col_ff[ADDR_WIDTH-1:0];
         s1_border_ff <= border;
         fwd_data_ff  <= wr_data;
      end
      if (s1_move && s1_emit_ff) begin
         s2_sum_ff  <= sum_in;
         s2_last_ff <= s1_border_ff.last;
      end
      if (s2_valid_ff && s3_free) begin
         rsp_mean_ff <= product[RECIP_SHIFT+PIXEL_WIDTH-1:RECIP_SHIFT];
         rsp_last_ff <= s2_last_ff;
      end
   end

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.mean  = rsp_mean_ff;
   assign rsp_port.last  = rsp_last_ff;

   // The input column never reaches the row width.
   a_in_col_range: assert property (@(posedge clock) disable iff (reset)
      in_col_ff < w_eff)
      else $error("input column beyond the row width");

   // The output position stays inside the frame.
   a_out_col_range: assert property (@(posedge clock) disable iff (reset)
      out_col_ff < w_eff)
      else $error("output column beyond the row width");

   a_out_row_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, out_row_ff} < h_eff)
      else $error("output row beyond the frame height");

   // Input rows run at most two rows past the frame before the last result.
   a_in_row_range: assert property (@(posedge clock) disable iff (reset)
      in_row_ff <= (h_eff + FRAME_HEIGHT_BITS'(1)))
      else $error("input row ran past the flush rows");

   // A stalled line store stage keeps its read data.
   a_stall_holds_read: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> $stable(rd_data))
      else $error("line store read data changed during a stall");

endmodule

`default_nettype wire

/* rtl/bf3zp_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module bf3zp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port: the old contents are returned when both ports hit one entry.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
